>>> sv/tlr_pkg.sv
// ============================================================================
// tlr_pkg: shared types and constants for the text line renderer
// Request formats, the internal command format and character codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tlr_pkg;

  // Character codes, 7-bit
  localparam logic [6:0] CH_TAB     = 7'h09;
  localparam logic [6:0] CH_LF      = 7'h0a;
  localparam logic [6:0] CH_CR      = 7'h0d;
  localparam logic [6:0] CH_EOF     = 7'h1a;
  localparam logic [6:0] CH_SPACE   = 7'h20;
  localparam logic [6:0] CH_CARET   = 7'h5e;
  localparam logic [6:0] CTRL_BIAS  = 7'h40;
  localparam logic [6:0] CH_NONE    = 7'h00;

  // Result kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_EOL   = 2'd1;
  localparam logic [1:0] KIND_EOF   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_H_OFFSET     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 1'd1;

  localparam logic [7:0] WINDOW_WIDTH_RST = 8'd80;

  // Most results one input byte may cause
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CNT_W       = 4;

  // Input request
  typedef struct packed {
    logic [7:0] text_byte;
    logic       show;
  } item_t;

  // Result request
  typedef struct packed {
    logic [6:0] out_char;
    logic [1:0] kind;
    logic       last;
  } result_t;

  // Configuration write
  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;
  } cfg_wr_t;

  // Command classes handed from front to back
  typedef enum logic [2:0] {
    OP_PRINT,
    OP_EOF,
    OP_NL,
    OP_CR,
    OP_TAB,
    OP_CTRL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] ch;
    logic       show;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/tlr_front.sv
// ============================================================================
// tlr_front: input classifier and command queue
// Takes text bytes, sorts them into command classes and queues them for the
// back end. Bytes that produce nothing and touch no state are dropped here.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tlr_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire tlr_pkg::item_t item,
  output logic                cmd_valid,
  output tlr_pkg::cmd_t       cmd,
  input  wire logic           cmd_pop
);

  logic          [1:0] count;
  logic                wr_ptr;
  logic                rd_ptr;
  tlr_pkg::cmd_t       mem [2];
  tlr_pkg::cmd_t       cls;
  logic                keep;
  logic                wr_en;

  // Classify the incoming byte
  always_comb begin
    cls.ch   = item.text_byte[6:0];
    cls.show = item.show;
    if (item.text_byte[6:0] >= tlr_pkg::CH_SPACE) begin
      cls.op = tlr_pkg::OP_PRINT;
    end else begin
      unique case (item.text_byte[6:0])
        tlr_pkg::CH_EOF: cls.op = tlr_pkg::OP_EOF;
        tlr_pkg::CH_LF:  cls.op = tlr_pkg::OP_NL;
        tlr_pkg::CH_CR:  cls.op = tlr_pkg::OP_CR;
        tlr_pkg::CH_TAB: cls.op = tlr_pkg::OP_TAB;
        default:         cls.op = tlr_pkg::OP_CTRL;
      endcase
    end
    // without show, printable, tab and control bytes do nothing at all
    keep = item.show || cls.op == tlr_pkg::OP_EOF || cls.op == tlr_pkg::OP_NL ||
           cls.op == tlr_pkg::OP_CR;
  end

  assign full      = (count == 2'd2);
  assign wr_en     = push && !full && keep;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr_en, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/tlr_back.sv
// ============================================================================
// tlr_back: column sequencer and result queue
// Runs one command at a time against the column counter, one step per cycle
// unless the two-entry output queue it writes results into is full.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tlr_back #(
  parameter int unsigned TAB_STOP = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tlr_pkg::cfg_wr_t cfg_wr,
  input  wire logic             cmd_valid,
  input  wire tlr_pkg::cmd_t    cmd,
  output logic                  cmd_pop,
  output logic                  empty,
  input  wire logic             pop,
  output tlr_pkg::result_t      result
);

  localparam int unsigned MOD_W = $clog2(TAB_STOP);
  localparam int unsigned REM_W = $clog2(TAB_STOP + 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t                      state, state_next;
  tlr_pkg::cmd_t               cur, cur_next;
  logic [15:0]                 column, column_next;
  logic [MOD_W-1:0]            col_mod, col_mod_next;
  logic [REM_W-1:0]            rem, rem_next;
  logic [tlr_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic [1:0]                  step, step_next;
  logic [7:0]                  h_offset;
  logic [7:0]                  window_width;

  logic                        res_push;
  tlr_pkg::result_t            res_new;
  tlr_pkg::result_t            out_mem [2];
  logic                        out_wr;
  logic                        out_rd;
  logic [1:0]                  out_count;
  logic                        out_full;
  logic                        out_pop;

  logic [8:0]                  hi;
  logic [15:0]                 col_inc;
  logic [MOD_W-1:0]            mod_inc;
  logic                        vis_inc;
  logic                        ctrl_fit;

  // Window bounds and one column advance, saturating
  always_comb begin
    hi       = {1'b0, h_offset} + {1'b0, window_width};
    col_inc  = (column == 16'hffff) ? column : column + 16'd1;
    if (column == 16'hffff) begin
      mod_inc = col_mod;
    end else if (col_mod == MOD_W'(TAB_STOP - 1)) begin
      mod_inc = '0;
    end else begin
      mod_inc = col_mod + MOD_W'(1);
    end
    vis_inc  = (col_inc > {8'd0, h_offset}) && (col_inc <= {7'd0, hi});
    ctrl_fit = (col_inc > {8'd0, h_offset}) &&
               (({1'b0, col_inc} + 17'd1) <= {8'd0, hi});
  end

  assign out_full = (out_count == 2'd2);
  assign empty    = (out_count == 2'd0);
  assign out_pop  = pop && !empty;
  assign result   = out_mem[out_rd];

  // Sequencer next state
  always_comb begin
    logic done;
    done         = 1'b0;
    state_next   = state;
    cur_next     = cur;
    column_next  = column;
    col_mod_next = col_mod;
    rem_next     = rem;
    cnt_next     = cnt;
    step_next    = step;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res_new      = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          cur_next   = cmd;
          rem_next   = REM_W'(TAB_STOP) - REM_W'(col_mod);
          cnt_next   = '0;
          step_next  = 2'd0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (!out_full) begin
          unique case (cur.op)
            tlr_pkg::OP_PRINT: begin
              column_next  = col_inc;
              col_mod_next = mod_inc;
              res_push     = vis_inc;
              res_new      = '{out_char: cur.ch, kind: tlr_pkg::KIND_CHAR, last: 1'b1};
              done         = 1'b1;
            end
            tlr_pkg::OP_EOF: begin
              res_push = 1'b1;
              res_new  = '{out_char: tlr_pkg::CH_NONE, kind: tlr_pkg::KIND_EOF,
                           last: 1'b1};
              done     = 1'b1;
            end
            tlr_pkg::OP_NL: begin
              res_push = 1'b1;
              if (cur.show && step == 2'd0) begin
                res_new   = '{out_char: tlr_pkg::CH_LF, kind: tlr_pkg::KIND_CHAR,
                              last: 1'b0};
                step_next = 2'd1;
              end else if (cur.show && step == 2'd1) begin
                res_new   = '{out_char: tlr_pkg::CH_CR, kind: tlr_pkg::KIND_CHAR,
                              last: 1'b0};
                step_next = 2'd2;
              end else begin
                res_new      = '{out_char: tlr_pkg::CH_NONE, kind: tlr_pkg::KIND_EOL,
                                 last: 1'b1};
                column_next  = '0;
                col_mod_next = '0;
                done         = 1'b1;
              end
            end
            tlr_pkg::OP_CR: begin
              column_next  = '0;
              col_mod_next = '0;
              res_push     = cur.show;
              res_new      = '{out_char: tlr_pkg::CH_CR, kind: tlr_pkg::KIND_CHAR,
                               last: 1'b1};
              done         = 1'b1;
            end
            tlr_pkg::OP_TAB: begin
              // one space per step; visible columns form one run, so the
              // last visible one is where the tab, the window or the cap ends
              column_next  = col_inc;
              col_mod_next = mod_inc;
              rem_next     = rem - REM_W'(1);
              if (vis_inc && cnt < tlr_pkg::CNT_W'(tlr_pkg::MAX_RESULTS)) begin
                res_push = 1'b1;
                cnt_next = cnt + tlr_pkg::CNT_W'(1);
                res_new  = '{out_char: tlr_pkg::CH_SPACE, kind: tlr_pkg::KIND_CHAR,
                             last: (rem == REM_W'(1)) || (col_inc == {7'd0, hi}) ||
                                   (cnt == tlr_pkg::CNT_W'(tlr_pkg::MAX_RESULTS - 1))};
              end
              done = (rem == REM_W'(1));
            end
            tlr_pkg::OP_CTRL: begin
              column_next  = col_inc;
              col_mod_next = mod_inc;
              if (step == 2'd0) begin
                if (ctrl_fit) begin
                  res_push  = 1'b1;
                  res_new   = '{out_char: tlr_pkg::CH_CARET, kind: tlr_pkg::KIND_CHAR,
                                last: 1'b0};
                  step_next = 2'd1;
                end else begin
                  done = 1'b1;
                end
              end else begin
                res_push = 1'b1;
                res_new  = '{out_char: cur.ch | tlr_pkg::CTRL_BIAS,
                             kind: tlr_pkg::KIND_CHAR, last: 1'b1};
                done     = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
          if (done) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column       <= '0;
      col_mod      <= '0;
      h_offset     <= '0;
      window_width <= tlr_pkg::WINDOW_WIDTH_RST;
    end else begin
      state   <= state_next;
      column  <= column_next;
      col_mod <= col_mod_next;
      if (cfg_wr.en) begin
        unique case (cfg_wr.index)
          tlr_pkg::REG_H_OFFSET:     h_offset     <= cfg_wr.data;
          tlr_pkg::REG_WINDOW_WIDTH: window_width <= cfg_wr.data;
          default: ;
        endcase
      end
    end
    cur  <= cur_next;
    rem  <= rem_next;
    cnt  <= cnt_next;
    step <= step_next;
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      out_mem[out_wr] <= res_new;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= 2'd0;
      out_wr    <= 1'b0;
      out_rd    <= 1'b0;
    end else begin
      if (res_push) begin
        out_wr <= !out_wr;
      end
      if (out_pop) begin
        out_rd <= !out_rd;
      end
      case ({res_push, out_pop})
        2'b10:   out_count <= out_count + 2'd1;
        2'b01:   out_count <= out_count - 2'd1;
        default: out_count <= out_count;
      endcase
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_push && out_full && !out_pop))
    else $error("result queue overflow");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !res_push)
    else $error("result written while sequencer idle");

  a_eol_last: assert property (@(posedge clk) disable iff (rst)
    res_push && res_new.kind == tlr_pkg::KIND_EOL |-> res_new.last)
    else $error("end of line marker not final");

  a_eol_column: assert property (@(posedge clk) disable iff (rst)
    res_push && res_new.kind == tlr_pkg::KIND_EOL |=> column == 16'd0 && col_mod == '0)
    else $error("column not cleared after end of line");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> state == S_RUN)
    else $error("command taken without starting it");

endmodule

`default_nettype wire

>>> sv/text_line_renderer.sv
// ============================================================================
// text_line_renderer: tab-expanding terminal line renderer
// Renders 7-bit text against a column counter into a horizontal window.
//
//   channel   direction  handshake          payload
//   input     in         push / full        item   (text_byte, show)
//   result    out        empty / pop        result (out_char, kind, last)
//   config    in         cfg_valid/ready    cfg_index, cfg_data
//
// A byte leaves the command queue, then takes one sequencer step per advance
// or result: caret and character for a control byte, line feed, carriage
// return and end of line for a shown newline, columns up to the tab stop for
// a tab. Bytes that produce nothing and touch no state skip the sequencer.
// The sequencer stalls while the two-entry result queue is full; the input
// side keeps accepting until the two-entry command queue fills.
// Reset is synchronous and clears the column and both registers to defaults.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module text_line_renderer #(
  parameter int unsigned TAB_STOP = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire tlr_pkg::item_t                    item,
  output logic                                   empty,
  input  wire logic                              pop,
  output tlr_pkg::result_t                       result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tlr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [7:0]                        cfg_data
);

  logic             cmd_valid;
  tlr_pkg::cmd_t    cmd;
  logic             cmd_pop;
  tlr_pkg::cfg_wr_t cfg_wr;

  // Register writes are always taken
  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  tlr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tlr_back #(
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire
